@@ sv/ldc_pkg.sv @@
// ldc_pkg: types and constants of the lens distortion correction block
// (register codes, reset values, pipeline context and map-stage structs).
// No dependencies.
package ldc_pkg;

  localparam int R_W       = 26;  // radius, 16 fraction bits
  localparam int N_W       = 52;  // square-root operand width
  localparam int SQ_STEPS  = 26;  // one result bit per stage
  localparam int HZ_STEPS  = 4;   // polynomial steps after the fourth-order term
  localparam int Q_W       = 41;  // quotient bits kept
  localparam int DIV_STEPS = 41;  // one quotient bit per stage

  localparam logic [Q_W-1:0] Q_CAP = 41'd1 << 40;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COEF_CONST,
    REG_COEF_LIN,
    REG_COEF_QUAD,
    REG_COEF_CUBIC,
    REG_COEF_QUART,
    REG_OUTPUT_SCALE
  } reg_idx_e;

  localparam logic [9:0]         RST_FRAME_WIDTH  = 10'd512;
  localparam logic [9:0]         RST_FRAME_HEIGHT = 10'd512;
  localparam logic signed [63:0] RST_COEF_CONST   = -64'sd72043182519120350;
  localparam logic signed [63:0] RST_COEF_LIN     = -64'sd31656342212743;
  localparam logic signed [63:0] RST_COEF_QUAD    = 64'sd103236914978;
  localparam logic signed [63:0] RST_COEF_CUBIC   = -64'sd205551493;
  localparam logic signed [63:0] RST_COEF_QUART   = 64'sd70777;
  localparam logic [15:0]        RST_OUTPUT_SCALE = 16'd5530;

  // what travels with every transaction down the pipeline
  typedef struct packed {
    logic              vld;
    logic              query;
    logic              wr_ok;
    logic [8:0]        col;
    logic [8:0]        row;
    logic [23:0]       pix;
    logic signed [9:0] dx;
    logic signed [9:0] dy;
    logic [8:0]        cx;
    logic [8:0]        cy;
    logic [9:0]        wm1;
    logic [9:0]        hm1;
    logic [R_W-1:0]    r;
  } ctx_t;

  typedef struct packed {
    logic [63:0] d;
    logic        szero;
    logic        negx;
    logic        negy;
    logic        ovfx;
    logic        ovfy;
  } map_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       in_range;
  } out_t;

endpackage

@@ sv/lens_distortion_correct.sv @@
// lens_distortion_correct: radial lens distortion correction with bilinear
// resampling from a four-bank frame store. Depends on ldc_pkg.
//
// One transaction per clock while the output queue is not full, loads and queries
// alike: a pipelined square root (one bit per stage), four polynomial steps
// of three stages each, a pipelined divider (one quotient bit per stage, both
// axes side by side), then address, frame read, weighting and sum stages. The
// frame is split into four banks by column and row parity, so the four
// neighbors of a sample come out of a single read. Loads write the store in the
// same stage where queries read it, which keeps them in order with queries. A
// two-entry output queue lets the pipeline run while a result waits to be taken.
module lens_distortion_correct import ldc_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [8:0]  col_i,
  input  logic [8:0]  row_i,
  input  logic [7:0]  pix_blue_i,
  input  logic [7:0]  pix_green_i,
  input  logic [7:0]  pix_red_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_red_o,
  output logic        in_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW         = $clog2(BANK_DEPTH);

  // ---------------- configuration registers ----------------
  logic [9:0]         frame_width_q, frame_height_q;
  logic signed [63:0] coef_const_q, coef_lin_q, coef_quad_q, coef_cubic_q, coef_quart_q;
  logic [15:0]        output_scale_q;
  reg_idx_e           cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      coef_const_q   <= RST_COEF_CONST;
      coef_lin_q     <= RST_COEF_LIN;
      coef_quad_q    <= RST_COEF_QUAD;
      coef_cubic_q   <= RST_COEF_CUBIC;
      coef_quart_q   <= RST_COEF_QUART;
      output_scale_q <= RST_OUTPUT_SCALE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[9:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[9:0];
        REG_COEF_CONST:   coef_const_q   <= pwdata;
        REG_COEF_LIN:     coef_lin_q     <= pwdata;
        REG_COEF_QUAD:    coef_quad_q    <= pwdata;
        REG_COEF_CUBIC:   coef_cubic_q   <= pwdata;
        REG_COEF_QUART:   coef_quart_q   <= pwdata;
        REG_OUTPUT_SCALE: output_scale_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 64'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = 64'(frame_height_q);
      REG_COEF_CONST:   prdata = coef_const_q;
      REG_COEF_LIN:     prdata = coef_lin_q;
      REG_COEF_QUAD:    prdata = coef_quad_q;
      REG_COEF_CUBIC:   prdata = coef_cubic_q;
      REG_COEF_QUART:   prdata = coef_quart_q;
      REG_OUTPUT_SCALE: prdata = 64'(output_scale_q);
    endcase
  end

  // ---------------- flow control ----------------
  logic       adv;
  logic [1:0] cnt_q;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  // ---------------- input stage ----------------
  logic [9:0]        w_c, h_c;
  logic [8:0]        cx_c, cy_c;
  logic signed [9:0] dx_c, dy_c;
  logic [19:0]       sqx_c, sqy_c, n_c;
  ctx_t              ctx_in_c;

  always_comb begin
    if (frame_width_q < 10'd2) begin
      w_c = 10'd2;
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_c = 10'(MAX_WIDTH);
    end else begin
      w_c = frame_width_q;
    end
    if (frame_height_q < 10'd2) begin
      h_c = 10'd2;
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_c = 10'(MAX_HEIGHT);
    end else begin
      h_c = frame_height_q;
    end
    cx_c  = w_c[9:1];
    cy_c  = h_c[9:1];
    dx_c  = $signed({1'b0, col_i}) - $signed({1'b0, cx_c});
    dy_c  = $signed({1'b0, row_i}) - $signed({1'b0, cy_c});
    sqx_c = 20'(dx_c * dx_c);
    sqy_c = 20'(dy_c * dy_c);
    n_c   = sqx_c + sqy_c;

    ctx_in_c       = '0;
    ctx_in_c.vld   = in_valid_i;
    ctx_in_c.query = func_i;
    ctx_in_c.wr_ok = (32'(col_i) < MAX_WIDTH) && (32'(row_i) < MAX_HEIGHT);
    ctx_in_c.col   = col_i;
    ctx_in_c.row   = row_i;
    ctx_in_c.pix   = {pix_red_i, pix_green_i, pix_blue_i};
    ctx_in_c.dx    = dx_c;
    ctx_in_c.dy    = dy_c;
    ctx_in_c.cx    = cx_c;
    ctx_in_c.cy    = cy_c;
    ctx_in_c.wm1   = w_c - 10'd1;
    ctx_in_c.hm1   = h_c - 10'd1;
  end

  // ---------------- square root, one bit per stage ----------------
  ctx_t           sq_ctx_q [SQ_STEPS+1];
  logic [N_W-1:0] sq_rem_q [SQ_STEPS+1];
  logic [N_W-1:0] sq_res_q [SQ_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ctx_q[0] <= '0;
      sq_rem_q[0] <= '0;
      sq_res_q[0] <= '0;
    end else if (adv) begin
      sq_ctx_q[0] <= ctx_in_c;
      sq_rem_q[0] <= N_W'({n_c[18:0], 32'b0});
      sq_res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [N_W-1:0] bitv, trial, rem_d, res_d;
    always_comb begin
      bitv  = N_W'(1) << (2 * (SQ_STEPS - 1 - k));
      trial = sq_res_q[k] + bitv;
      if (sq_rem_q[k] >= trial) begin
        rem_d = sq_rem_q[k] - trial;
        res_d = (sq_res_q[k] >> 1) + bitv;
      end else begin
        rem_d = sq_rem_q[k];
        res_d = sq_res_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_ctx_q[k+1] <= '0;
        sq_rem_q[k+1] <= '0;
        sq_res_q[k+1] <= '0;
      end else if (adv) begin
        sq_ctx_q[k+1] <= sq_ctx_q[k];
        sq_rem_q[k+1] <= rem_d;
        sq_res_q[k+1] <= res_d;
      end
    end
  end

  // ---------------- polynomial, Horner steps of three stages ----------------
  logic signed [63:0] coef_step [HZ_STEPS];
  ctx_t               hz_a_ctx_q [HZ_STEPS];
  ctx_t               hz_b_ctx_q [HZ_STEPS];
  ctx_t               hz_c_ctx_q [HZ_STEPS];
  logic               hz_neg_q   [HZ_STEPS];
  logic [57:0]        hz_phi_q   [HZ_STEPS];
  logic [57:0]        hz_plo_q   [HZ_STEPS];
  logic signed [63:0] hz_prod_q  [HZ_STEPS];
  logic signed [63:0] hz_acc_q   [HZ_STEPS];

  always_comb begin
    coef_step[0] = coef_cubic_q;
    coef_step[1] = coef_quad_q;
    coef_step[2] = coef_lin_q;
    coef_step[3] = coef_const_q;
  end

  for (genvar j = 0; j < HZ_STEPS; j++) begin : g_horner
    ctx_t               ctx_src;
    logic signed [63:0] acc_src;
    logic [63:0]        mag, lim, p;
    logic signed [64:0] sum;
    logic signed [63:0] acc_d;

    if (j == 0) begin : g_first
      always_comb begin
        ctx_src   = sq_ctx_q[SQ_STEPS];
        ctx_src.r = sq_res_q[SQ_STEPS][R_W-1:0];
      end
      assign acc_src = coef_quart_q;
    end else begin : g_next
      assign ctx_src = hz_c_ctx_q[j-1];
      assign acc_src = hz_acc_q[j-1];
    end

    always_comb begin
      mag = acc_src[63] ? 64'(-acc_src) : 64'(acc_src);
      lim = hz_neg_q[j] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (hz_phi_q[j] >= (58'd1 << 47)) begin
        p = lim;
      end else begin
        p = 64'({hz_phi_q[j][46:0], 16'b0}) + 64'(hz_plo_q[j] >> 16);
        if (p > lim) begin
          p = lim;
        end
      end
      sum = 65'(hz_prod_q[j]) + 65'(coef_step[j]);
      if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
        acc_d = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (sum < -65'sh0_8000_0000_0000_0000) begin
        acc_d = 64'sh8000_0000_0000_0000;
      end else begin
        acc_d = sum[63:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hz_a_ctx_q[j] <= '0;
        hz_b_ctx_q[j] <= '0;
        hz_c_ctx_q[j] <= '0;
        hz_neg_q[j]   <= 1'b0;
        hz_phi_q[j]   <= '0;
        hz_plo_q[j]   <= '0;
        hz_prod_q[j]  <= '0;
        hz_acc_q[j]   <= '0;
      end else if (adv) begin
        // partial products of the magnitude times r
        hz_a_ctx_q[j] <= ctx_src;
        hz_neg_q[j]   <= acc_src[63];
        hz_phi_q[j]   <= 58'(mag[63:32] * ctx_src.r);
        hz_plo_q[j]   <= 58'(mag[31:0] * ctx_src.r);
        // scale down and clamp
        hz_b_ctx_q[j] <= hz_a_ctx_q[j];
        hz_prod_q[j]  <= hz_neg_q[j] ? $signed(-p) : $signed(p);
        // saturating add of the next coefficient
        hz_c_ctx_q[j] <= hz_b_ctx_q[j];
        hz_acc_q[j]   <= acc_d;
      end
    end
  end

  // ---------------- divider setup ----------------
  ctx_t               hz_ctx;
  logic signed [63:0] s_c;
  logic [9:0]         dxn_c, dyn_c;
  logic [8:0]         adx_c, ady_c;
  logic [24:0]        nmx_c, nmy_c;
  logic [63:0]        remx0_c, remy0_c;
  map_t               mp_c;

  always_comb begin
    hz_ctx   = hz_c_ctx_q[HZ_STEPS-1];
    s_c      = hz_acc_q[HZ_STEPS-1];
    dxn_c    = 10'(-hz_ctx.dx);
    dyn_c    = 10'(-hz_ctx.dy);
    adx_c    = hz_ctx.dx[9] ? dxn_c[8:0] : hz_ctx.dx[8:0];
    ady_c    = hz_ctx.dy[9] ? dyn_c[8:0] : hz_ctx.dy[8:0];
    nmx_c    = 25'(adx_c * output_scale_q);
    nmy_c    = 25'(ady_c * output_scale_q);
    remx0_c  = 64'({nmx_c, 19'b0});
    remy0_c  = 64'({nmy_c, 19'b0});
    mp_c.d     = s_c[63] ? 64'(-s_c) : 64'(s_c);
    mp_c.szero = (s_c == 64'sd0);
    mp_c.negx  = hz_ctx.dx[9] ^ s_c[63];
    mp_c.negy  = hz_ctx.dy[9] ^ s_c[63];
    // a quotient of 2^41 or more is capped anyway
    mp_c.ovfx  = (remx0_c >= mp_c.d);
    mp_c.ovfy  = (remy0_c >= mp_c.d);
  end

  // ---------------- divider, one quotient bit per stage ----------------
  ctx_t           dv_ctx_q [DIV_STEPS+1];
  map_t           dv_mp_q  [DIV_STEPS+1];
  logic [63:0]    dv_rx_q  [DIV_STEPS+1];
  logic [63:0]    dv_ry_q  [DIV_STEPS+1];
  logic [Q_W-1:0] dv_qx_q  [DIV_STEPS+1];
  logic [Q_W-1:0] dv_qy_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_ctx_q[0] <= '0;
      dv_mp_q[0]  <= '0;
      dv_rx_q[0]  <= '0;
      dv_ry_q[0]  <= '0;
      dv_qx_q[0]  <= '0;
      dv_qy_q[0]  <= '0;
    end else if (adv) begin
      dv_ctx_q[0] <= hz_ctx;
      dv_mp_q[0]  <= mp_c;
      dv_rx_q[0]  <= remx0_c;
      dv_ry_q[0]  <= remy0_c;
      dv_qx_q[0]  <= '0;
      dv_qy_q[0]  <= '0;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [63:0] rx2, ry2, rx_d, ry_d;
    logic        bx, by;
    always_comb begin
      rx2  = {dv_rx_q[i][62:0], 1'b0};
      ry2  = {dv_ry_q[i][62:0], 1'b0};
      bx   = (rx2 >= dv_mp_q[i].d);
      by   = (ry2 >= dv_mp_q[i].d);
      rx_d = bx ? rx2 - dv_mp_q[i].d : rx2;
      ry_d = by ? ry2 - dv_mp_q[i].d : ry2;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_ctx_q[i+1] <= '0;
        dv_mp_q[i+1]  <= '0;
        dv_rx_q[i+1]  <= '0;
        dv_ry_q[i+1]  <= '0;
        dv_qx_q[i+1]  <= '0;
        dv_qy_q[i+1]  <= '0;
      end else if (adv) begin
        dv_ctx_q[i+1] <= dv_ctx_q[i];
        dv_mp_q[i+1]  <= dv_mp_q[i];
        dv_rx_q[i+1]  <= rx_d;
        dv_ry_q[i+1]  <= ry_d;
        dv_qx_q[i+1]  <= {dv_qx_q[i][Q_W-2:0], bx};
        dv_qy_q[i+1]  <= {dv_qy_q[i][Q_W-2:0], by};
      end
    end
  end

  // ---------------- mapped point and range check ----------------
  ctx_t           dv_ctx;
  map_t           dv_mp;
  logic [Q_W-1:0] qx_c, qy_c;
  logic [47:0]    basex_c, basey_c, mx_c, my_c;
  logic           ok_c;

  always_comb begin
    dv_ctx  = dv_ctx_q[DIV_STEPS];
    dv_mp   = dv_mp_q[DIV_STEPS];
    qx_c    = (dv_mp.ovfx || dv_qx_q[DIV_STEPS] > Q_CAP) ? Q_CAP : dv_qx_q[DIV_STEPS];
    qy_c    = (dv_mp.ovfy || dv_qy_q[DIV_STEPS] > Q_CAP) ? Q_CAP : dv_qy_q[DIV_STEPS];
    basex_c = {23'b0, dv_ctx.cx, 16'b0};
    basey_c = {23'b0, dv_ctx.cy, 16'b0};
    mx_c    = dv_mp.negx ? basex_c - 48'(qx_c) : basex_c + 48'(qx_c);
    my_c    = dv_mp.negy ? basey_c - 48'(qy_c) : basey_c + 48'(qy_c);
    ok_c    = !dv_mp.szero
           && !mx_c[47] && (mx_c[46:0] < {21'b0, dv_ctx.wm1, 16'b0})
           && !my_c[47] && (my_c[46:0] < {21'b0, dv_ctx.hm1, 16'b0});
  end

  ctx_t          sl_ctx_q;
  logic          sl_ok_q;
  logic [XW-1:0] sl_xi_q;
  logic [YW-1:0] sl_yi_q;
  logic [15:0]   sl_fx_q, sl_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_ctx_q <= '0;
      sl_ok_q  <= 1'b0;
      sl_xi_q  <= '0;
      sl_yi_q  <= '0;
      sl_fx_q  <= '0;
      sl_fy_q  <= '0;
    end else if (adv) begin
      sl_ctx_q <= dv_ctx;
      sl_ok_q  <= ok_c;
      sl_xi_q  <= mx_c[16 +: XW];
      sl_yi_q  <= my_c[16 +: YW];
      sl_fx_q  <= mx_c[15:0];
      sl_fy_q  <= my_c[15:0];
    end
  end

  // ---------------- banked frame store ----------------
  // bank {row parity, column parity}; even banks hold (xi+1)>>1, odd ones xi>>1
  logic [XW:0]   xp1_c;
  logic [YW:0]   yp1_c;
  logic [XW-1:0] ex_c, ox_c;
  logic [YW-1:0] ey_c, oy_c;
  logic [1:0]    wr_bank_c;
  logic [AW-1:0] wr_addr_c;
  logic          wr_en_c;
  logic [23:0]   rdata_q [4];

  always_comb begin
    xp1_c     = {1'b0, sl_xi_q} + 1'b1;
    yp1_c     = {1'b0, sl_yi_q} + 1'b1;
    ex_c      = xp1_c[XW:1];
    ey_c      = yp1_c[YW:1];
    ox_c      = sl_xi_q >> 1;
    oy_c      = sl_yi_q >> 1;
    wr_bank_c = {sl_ctx_q.row[0], sl_ctx_q.col[0]};
    wr_addr_c = AW'(32'(sl_ctx_q.row[8:1]) * HALF_W) + AW'(sl_ctx_q.col[8:1]);
    wr_en_c   = sl_ctx_q.vld && !sl_ctx_q.query && sl_ctx_q.wr_ok;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0]   mem [BANK_DEPTH];
    logic [XW-1:0] xh;
    logic [YW-1:0] yh;
    logic [AW-1:0] rd_addr;
    assign xh      = ((b & 1) != 0) ? ox_c : ex_c;
    assign yh      = ((b & 2) != 0) ? oy_c : ey_c;
    assign rd_addr = AW'(32'(yh) * HALF_W) + AW'(xh);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (wr_en_c && wr_bank_c == 2'(b)) begin
          mem[wr_addr_c] <= sl_ctx_q.pix;
        end
        rdata_q[b] <= mem[rd_addr];
      end
    end
  end

  logic        rd_vld_q, rd_ok_q, rd_xp_q, rd_yp_q;
  logic [32:0] rd_w_q [4];
  logic [16:0] gx_c, gy_c;

  assign gx_c = 17'h1_0000 - {1'b0, sl_fx_q};
  assign gy_c = 17'h1_0000 - {1'b0, sl_fy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_ok_q  <= 1'b0;
      rd_xp_q  <= 1'b0;
      rd_yp_q  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        rd_w_q[k] <= '0;
      end
    end else if (adv) begin
      rd_vld_q  <= sl_ctx_q.vld && sl_ctx_q.query;
      rd_ok_q   <= sl_ok_q;
      rd_xp_q   <= sl_xi_q[0];
      rd_yp_q   <= sl_yi_q[0];
      rd_w_q[0] <= 33'(gx_c * gy_c);
      rd_w_q[1] <= 33'({1'b0, sl_fx_q} * gy_c);
      rd_w_q[2] <= 33'(gx_c * {1'b0, sl_fy_q});
      rd_w_q[3] <= 33'(sl_fx_q * sl_fy_q);
    end
  end

  // ---------------- bilinear weighting ----------------
  logic [23:0] nb_c [4];
  logic        pr_vld_q, pr_ok_q;
  logic [40:0] pr_q [3][4];

  always_comb begin
    nb_c[0] = rdata_q[{rd_yp_q, rd_xp_q}];
    nb_c[1] = rdata_q[{rd_yp_q, !rd_xp_q}];
    nb_c[2] = rdata_q[{!rd_yp_q, rd_xp_q}];
    nb_c[3] = rdata_q[{!rd_yp_q, !rd_xp_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
      pr_ok_q  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          pr_q[c][k] <= '0;
        end
      end
    end else if (adv) begin
      pr_vld_q <= rd_vld_q;
      pr_ok_q  <= rd_ok_q;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          pr_q[c][k] <= 41'(nb_c[k][8*c +: 8] * rd_w_q[k]);
        end
      end
    end
  end

  out_t        res_c;
  logic [42:0] sum_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = 43'(pr_q[c][0]) + 43'(pr_q[c][1]) + 43'(pr_q[c][2]) + 43'(pr_q[c][3]);
    end
    res_c.blue     = pr_ok_q ? sum_c[0][39:32] : 8'd0;
    res_c.green    = pr_ok_q ? sum_c[1][39:32] : 8'd0;
    res_c.red      = pr_ok_q ? sum_c[2][39:32] : 8'd0;
    res_c.in_range = pr_ok_q;
  end

  // ---------------- output queue ----------------
  out_t fifo_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic push, pop;
  out_t head;

  assign push        = adv && pr_vld_q;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign head        = fifo_q[rd_ptr_q];
  assign out_blue_o  = head.blue;
  assign out_green_o = head.green;
  assign out_red_o   = head.red;
  assign in_range_o  = head.in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_c;
    end
  end

endmodule

@@ sv/ldc_checker.sv @@
// ldc_checker: port-level checks of lens_distortion_correct, with its bind.
// No dependencies beyond the top level's ports.
module ldc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_blue_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_red_o,
  input logic       in_range_o,
  input logic       pready
);

  // a result outside the frame carries no color
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> out_blue_o == 8'd0 && out_green_o == 8'd0
                                   && out_red_o == 8'd0)
    else $error("out of range result with nonzero color");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // stalled transaction keeps valid and payload
  a_hold_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({out_blue_o, out_green_o, out_red_o, in_range_o}))
    else $error("output payload changed while stalled");

endmodule

bind lens_distortion_correct ldc_checker u_ldc_checker (.*);
